// File: hdl/dars_pkg.sv
// Shared types and constants for the disk arm request scheduler.
package dars_pkg;

  localparam int CYL_W = 8;
  localparam int SUM_W = 13;
  localparam logic [SUM_W-1:0] SUM_MAX = 13'h1FFF;
  localparam logic [CYL_W-1:0] MAX_CYL = 8'd199;

  typedef enum logic [2:0] {
    POL_FCFS      = 3'd0,
    POL_SSTF      = 3'd1,
    POL_LOOK_UP   = 3'd2,
    POL_LOOK_DOWN = 3'd3,
    POL_CSCAN     = 3'd4,
    POL_SCAN_UP   = 3'd5,
    POL_SCAN_DOWN = 3'd6,
    POL_SPARE     = 3'd7
  } policy_t;

  typedef enum logic [1:0] {
    PICK_UP   = 2'd0,
    PICK_DOWN = 2'd1,
    PICK_NEAR = 2'd2,
    PICK_FIFO = 2'd3
  } pick_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // First sweep, second sweep, and the C-SCAN wrap stop at cylinder zero.
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_ZERO
  } phase_t;

  typedef struct packed {
    logic                action;
    logic [CYL_W-1:0]    cylinder;
  } in_item_t;

  typedef struct packed {
    logic [CYL_W-1:0]    visit_cylinder;
    logic [CYL_W-1:0]    move_distance;
    logic [SUM_W-1:0]    total_seek;
    logic                is_last;
  } out_item_t;

  // Token passed cell to cell during a selection scan.
  typedef struct packed {
    logic             found;
    logic [CYL_W-1:0] cyl;
    logic [CYL_W-1:0] gap;
  } tok_t;

  typedef struct packed {
    logic             clear;
    pick_t            pick;
    logic [CYL_W-1:0] pos;
  } cell_ctl_t;

  function automatic logic [CYL_W-1:0] absdiff(input logic [CYL_W-1:0] a,
                                               input logic [CYL_W-1:0] b);
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: hdl/dars_cell.sv
// One queue slot: holds a request, its served flag and compares against a passing token.
module dars_cell
  import dars_pkg::*;
#(
  parameter int IDX_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [CYL_W-1:0] load_cyl,
  input  cell_ctl_t        ctl,
  input  logic             active,
  input  tok_t             tok_in,
  input  logic [IDX_W-1:0] idx_in,
  output tok_t             tok_out,
  output logic [IDX_W-1:0] idx_out,
  input  logic             take,
  output logic             pending
);
  logic [CYL_W-1:0] req;
  logic             served;
  logic             valid;
  logic             ok;
  logic             better;
  logic [CYL_W-1:0] d;
  tok_t             tok;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid  <= 1'b0;
      served <= 1'b0;
    end else if (load) begin
      valid  <= 1'b1;
      served <= 1'b0;
    end else if (take) begin
      served <= 1'b1;
    end
    if (load) req <= load_cyl;
  end

  assign pending = valid && !served;
  assign d       = absdiff(req, ctl.pos);

  always_comb begin
    ok     = 1'b0;
    better = 1'b0;
    case (ctl.pick)
      PICK_UP:   begin ok = req >= ctl.pos; better = req < tok_in.cyl; end
      PICK_DOWN: begin ok = req <= ctl.pos; better = req > tok_in.cyl; end
      PICK_NEAR: begin ok = 1'b1;           better = d < tok_in.gap;   end
      PICK_FIFO: begin ok = 1'b1;           better = 1'b0;             end
      default:   begin ok = 1'b0;           better = 1'b0;             end
    endcase
  end

  assign tok.found = 1'b1;
  assign tok.cyl   = req;
  assign tok.gap   = d;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      idx_out <= '0;
    end else if (active && pending && ok && (!tok_in.found || better)) begin
      tok_out <= tok;
      idx_out <= IDX_W'(CELL_IDX);
    end else begin
      tok_out <= tok_in;
      idx_out <= idx_in;
    end
  end
endmodule

// File: hdl/disk_arm_request_scheduler_unit.sv
// Top level of the disk arm request scheduler: cell chain plus run sequencer.
//   channel  | handshake                        | payload
//   in       | in_valid / in_ready              | in_item_t  (action, cylinder)
//   out      | out_valid / out_ready            | out_item_t (stop, move, total, last)
//   cfg      | cfg_we                           | cfg_data (policy_mode)
// Loads can follow each other every cycle while idle.
// Each stop of a run costs a token scan over all cells, a decide state and
// an output state that waits for out_ready.
// A sweep change without a stop (LOOK, SCAN already at its end) adds a scan and a decide.
// The input is held off while a run is in progress; output stalls hold the run.
// Reset clears the queue, the policy and the arm state.
module disk_arm_request_scheduler_unit
  import dars_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data
);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  policy_t                policy;
  state_t                 state, state_next;
  phase_t                 phase;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       step;
  logic [CYL_W-1:0]       head;
  logic [SUM_W-1:0]       seek;
  logic [CYL_W-1:0]       hold_mv;
  logic [CYL_W-1:0]       in_cyl;
  tok_t                   chain [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]       chain_idx [QUEUE_DEPTH+1];
  tok_t                   win;
  logic [IDX_W-1:0]       win_idx;
  logic [QUEUE_DEPTH-1:0] pend;
  logic [QUEUE_DEPTH-1:0] take;
  cell_ctl_t              ctl;
  logic                   load;
  logic                   run_go;
  logic                   any_pend;
  logic                   scan_last;
  logic                   decide;
  logic                   take_fire;
  logic                   fin_ack;
  logic                   dec_stop;
  logic                   dec_take;
  logic                   dec_done;
  logic [CYL_W-1:0]       dec_cyl;
  phase_t                 dec_phase;
  logic [CYL_W-1:0]       end_cyl;
  logic [CYL_W-1:0]       mv;
  logic [SUM_W:0]         sum_w;
  logic [SUM_W-1:0]       sum_sat;

  assign in_cyl   = (in_data.cylinder > MAX_CYL) ? MAX_CYL : in_data.cylinder;
  assign load     = in_valid && in_ready && !in_data.action &&
                    (count < CNT_W'(QUEUE_DEPTH));
  assign run_go   = in_valid && in_ready && in_data.action;
  assign any_pend = |pend;

  always_ff @(posedge clk) begin
    if (rst) policy <= POL_FCFS;
    else if (cfg_we) policy <= policy_t'(cfg_data);
  end

  assign chain[0]     = '0;
  assign chain_idx[0] = '0;
  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      assign take[g] = take_fire && (win_idx == IDX_W'(g));
      dars_cell #(.IDX_W(IDX_W), .CELL_IDX(g)) u_cell (
        .clk(clk), .rst(rst),
        .load(load && (count == CNT_W'(g))), .load_cyl(in_cyl),
        .ctl(ctl), .active((state == ST_SCAN) && (step == CNT_W'(g))),
        .tok_in(chain[g]), .idx_in(chain_idx[g]),
        .tok_out(chain[g+1]), .idx_out(chain_idx[g+1]),
        .take(take[g]), .pending(pend[g])
      );
    end
  endgenerate

  assign win     = chain[QUEUE_DEPTH];
  assign win_idx = chain_idx[QUEUE_DEPTH];

  always_comb begin
    ctl.clear = fin_ack;
    ctl.pos   = head;
    case (policy)
      POL_SSTF:                     ctl.pick = PICK_NEAR;
      POL_LOOK_UP, POL_SCAN_UP:     ctl.pick = (phase == PH_FIRST) ? PICK_UP : PICK_DOWN;
      POL_LOOK_DOWN, POL_SCAN_DOWN: ctl.pick = (phase == PH_FIRST) ? PICK_DOWN : PICK_UP;
      POL_CSCAN:                    ctl.pick = PICK_UP;
      default:                      ctl.pick = PICK_FIFO;
    endcase
  end

  // Next stop after a scan: a queued request, a turnaround stop, a new sweep or the end.
  assign end_cyl = (policy == POL_SCAN_UP) ? MAX_CYL : '0;

  always_comb begin
    dec_stop  = 1'b0;
    dec_take  = 1'b0;
    dec_cyl   = win.cyl;
    dec_phase = phase;
    case (policy)
      POL_CSCAN: begin
        if (phase == PH_ZERO) begin
          dec_stop  = 1'b1;
          dec_cyl   = '0;
          dec_phase = PH_SECOND;
        end else if (win.found) begin
          dec_stop = 1'b1;
          dec_take = 1'b1;
        end else if (phase == PH_FIRST && any_pend) begin
          dec_stop  = 1'b1;
          dec_cyl   = MAX_CYL;
          dec_phase = PH_ZERO;
        end
      end
      POL_SCAN_UP, POL_SCAN_DOWN: begin
        if (win.found) begin
          dec_stop = 1'b1;
          dec_take = 1'b1;
        end else if (phase == PH_FIRST) begin
          dec_phase = PH_SECOND;
          if (head != end_cyl) begin
            dec_stop = 1'b1;
            dec_cyl  = end_cyl;
          end
        end
      end
      POL_LOOK_UP, POL_LOOK_DOWN: begin
        if (win.found) begin
          dec_stop = 1'b1;
          dec_take = 1'b1;
        end else if (phase == PH_FIRST) begin
          dec_phase = PH_SECOND;
        end
      end
      default: begin
        if (win.found) begin
          dec_stop = 1'b1;
          dec_take = 1'b1;
        end
      end
    endcase
    dec_done = !dec_stop && (dec_phase == phase);
  end

  assign mv      = absdiff(dec_cyl, head);
  assign sum_w   = {1'b0, seek} + {{(SUM_W-CYL_W+1){1'b0}}, mv};
  assign sum_sat = sum_w[SUM_W] ? SUM_MAX : sum_w[SUM_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (run_go) state_next = ST_SCAN;
      ST_SCAN:   if (scan_last) state_next = ST_DECIDE;
      ST_DECIDE: state_next = (dec_stop || dec_done) ? ST_EMIT : ST_SCAN;
      ST_EMIT:   if (out_ready) state_next = out_data.is_last ? ST_IDLE : ST_SCAN;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    scan_last = (state == ST_SCAN) && (step == CNT_W'(QUEUE_DEPTH - 1));
    decide    = (state == ST_DECIDE);
    take_fire = decide && dec_take;
    fin_ack   = (state == ST_EMIT) && out_ready && out_data.is_last;
  end

  // head and seek always describe the held stop; it leaves once the next step is known.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_FIRST;
      count     <= '0;
      step      <= '0;
      head      <= '0;
      seek      <= '0;
      hold_mv   <= '0;
      out_valid <= 1'b0;
      out_data  <= '0;
    end else begin
      state <= state_next;
      if (fin_ack) count <= '0;
      else if (load) count <= count + 1'b1;
      if (state == ST_SCAN) step <= step + 1'b1;
      else step <= '0;
      if (run_go) begin
        head    <= in_cyl;
        seek    <= '0;
        hold_mv <= '0;
        phase   <= PH_FIRST;
      end
      if (decide) begin
        phase <= dec_phase;
        if (dec_stop || dec_done) begin
          out_data.visit_cylinder <= head;
          out_data.move_distance  <= hold_mv;
          out_data.total_seek     <= seek;
          out_data.is_last        <= dec_done;
          out_valid               <= 1'b1;
        end
        if (dec_stop) begin
          head    <= dec_cyl;
          seek    <= sum_sat;
          hold_mv <= mv;
        end
      end
      if (state == ST_EMIT && out_ready) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_idle_no_output: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("output pending while idle");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output transaction changed while stalled");
  a_queue_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.is_last) |=> (count == '0))
    else $error("queue not cleared after run");
`endif
endmodule

// File: tb/sv/tb_disk_arm_request_scheduler_unit.sv
// Testbench for the disk arm request scheduler: every policy, queue limits, random runs.
module tb_disk_arm_request_scheduler_unit;
  import dars_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 32;
  localparam int MAXCYL = 199;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_data = '0;

  disk_arm_request_scheduler_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  policy_t  arm_policy;
  int       queued_cyl[QDEPTH];
  bit       done_flag[QDEPTH];
  int       queued_n;
  int       arm_pos;
  int       seek_total;
  out_item_t stop_q[$];
  int       errors = 0;

  // sender state
  in_item_t send_q[$];
  int       queued_cnt = 0;
  int       sent_cnt = 0;
  int       burst_left = 0;
  int       gap_left = 0;

  function automatic void add_stop(int cyl);
    out_item_t s;
    int d;
    d = (cyl >= arm_pos) ? cyl - arm_pos : arm_pos - cyl;
    seek_total = (seek_total + d > 8191) ? 8191 : seek_total + d;
    arm_pos = cyl;
    s.visit_cylinder = cyl[7:0];
    s.move_distance = d[7:0];
    s.total_seek = seek_total[12:0];
    s.is_last = 1'b0;
    stop_q.push_back(s);
  endfunction

  function automatic void take(int k);
    done_flag[k] = 1'b1;
    add_stop(queued_cyl[k]);
  endfunction

  // dir 0 up, 1 down, 2 nearest
  function automatic int choose(int dir);
    int best, bd, d;
    best = -1;
    bd = 0;
    for (int j = 0; j < queued_n; j++) begin
      if (done_flag[j]) continue;
      d = (queued_cyl[j] >= arm_pos) ? queued_cyl[j] - arm_pos : arm_pos - queued_cyl[j];
      if (dir == 0 && queued_cyl[j] >= arm_pos &&
          (best < 0 || queued_cyl[j] < queued_cyl[best])) best = j;
      if (dir == 1 && queued_cyl[j] <= arm_pos &&
          (best < 0 || queued_cyl[j] > queued_cyl[best])) best = j;
      if (dir == 2 && (best < 0 || d < bd)) begin
        best = j;
        bd = d;
      end
    end
    return best;
  endfunction

  function automatic void sweep(int dir);
    int k;
    k = choose(dir);
    while (k >= 0) begin
      take(k);
      k = choose(dir);
    end
  endfunction

  function automatic void predict_schedule(in_item_t it);
    int cyl;
    bit left;
    cyl = (it.cylinder > MAXCYL) ? MAXCYL : it.cylinder;
    if (!it.action) begin
      if (queued_n < QDEPTH) begin
        queued_cyl[queued_n] = cyl;
        done_flag[queued_n] = 1'b0;
        queued_n++;
      end
      return;
    end
    arm_pos = cyl;
    seek_total = 0;
    add_stop(cyl);
    case (arm_policy)
      POL_SSTF: sweep(2);
      POL_LOOK_UP: begin
        sweep(0);
        sweep(1);
      end
      POL_LOOK_DOWN: begin
        sweep(1);
        sweep(0);
      end
      POL_CSCAN: begin
        sweep(0);
        left = 1'b0;
        for (int j = 0; j < queued_n; j++) if (!done_flag[j]) left = 1'b1;
        if (left) begin
          add_stop(MAXCYL);
          add_stop(0);
          sweep(0);
        end
      end
      POL_SCAN_UP: begin
        sweep(0);
        if (arm_pos != MAXCYL) add_stop(MAXCYL);
        sweep(1);
      end
      POL_SCAN_DOWN: begin
        sweep(1);
        if (arm_pos != 0) add_stop(0);
        sweep(0);
      end
      default: for (int j = 0; j < queued_n; j++) take(j);
    endcase
    stop_q[$].is_last = 1'b1;
    queued_n = 0;
    for (int j = 0; j < QDEPTH; j++) done_flag[j] = 1'b0;
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    out_item_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (stop_q.size() == 0) begin
          $display("%0t: unexpected transaction, actual %p", $time, out_data);
          errors++;
        end else begin
          e = stop_q.pop_front();
          if (out_data.visit_cylinder !== e.visit_cylinder ||
              out_data.move_distance !== e.move_distance ||
              out_data.total_seek !== e.total_seek ||
              out_data.is_last !== e.is_last) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, e, out_data);
            errors++;
          end
        end
      end
      out_ready <= (($time / 400) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // input driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_schedule(in_data);
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (send_q.size() != 0) begin
          in_data <= send_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 8);
            gap_left = $urandom_range(0, 4);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic send_item(bit act, logic [7:0] cyl);
    in_item_t it;
    it.action = act;
    it.cylinder = cyl;
    send_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic drain();
    wait (sent_cnt == queued_cnt);
    while (stop_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_policy(policy_t p);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    arm_policy = p;
  endtask

  task automatic test_directed();
    set_policy(POL_FCFS);
    send_item(0, 8'd0);
    send_item(0, 8'd255);
    send_item(0, 8'd199);
    send_item(0, 8'd100);
    send_item(1, 8'd50);
    send_item(1, 8'd0);       // empty queue
    set_policy(POL_SSTF);
    send_item(0, 8'd40);
    send_item(0, 8'd60);      // tie, earliest wins
    send_item(0, 8'd0);
    send_item(1, 8'd50);
    set_policy(POL_SCAN_DOWN);
    send_item(1, 8'd77);      // empty queue still runs to end
    set_policy(POL_SCAN_UP);
    send_item(1, 8'd199);
    set_policy(POL_CSCAN);
    send_item(0, 8'd10);
    send_item(0, 8'd150);
    send_item(1, 8'd100);
    set_policy(POL_SPARE);
    send_item(0, 8'd170);
    send_item(0, 8'd170);
    send_item(1, 8'd255);
  endtask

  task automatic test_full_queue();
    set_policy(POL_LOOK_UP);
    for (int i = 0; i < 34; i++)
      send_item(0, (i == 33) ? 8'd255 : 8'($urandom_range(0, 199)));
    send_item(1, 8'd0);
    drain();
    set_policy(POL_SSTF);
    for (int i = 0; i < 33; i++) send_item(0, 8'($urandom_range(0, 255)));
    send_item(1, 8'd199);
  endtask

  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < 20) begin
      set_policy(policy_t'(3'($urandom_range(0, 7))));
      repeat ($urandom_range(1, 3)) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 34) : $urandom_range(0, 7);
        for (int i = 0; i < n; i++) send_item(0, 8'($urandom_range(0, 255)));
        send_item(1, 8'($urandom_range(0, 255)));
        sent += n + 1;
      end
    end
  endtask

  initial begin
    arm_policy = POL_FCFS;
    queued_n = 0;
    arm_pos = 0;
    seek_total = 0;
    for (int j = 0; j < QDEPTH; j++) done_flag[j] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_random();
    set_policy(POL_SCAN_DOWN);
    drain();
    if (errors == 0 && stop_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
hdl/dars_pkg.sv
hdl/dars_cell.sv
hdl/disk_arm_request_scheduler_unit.sv
tb/sv/tb_disk_arm_request_scheduler_unit.sv
